/* sv/lpt_pkg.sv */
// Shared types and constants for the listening port table.
`timescale 1ns / 1ps

package lpt_pkg;

  localparam int SET_DEPTH   = 256;
  localparam int TABLE_SLOTS = 127;

  localparam int IDX_W    = $clog2(SET_DEPTH);
  localparam int CNT_W    = $clog2(SET_DEPTH + 1);
  localparam int PORT_W   = 16;
  localparam int ADDR_W   = 32;
  localparam int EIDX_W   = 7;
  localparam int STATUS_W = 3;
  localparam int PCOUNT_W = 9;
  localparam int REQ_W    = 2;

  localparam logic [ADDR_W-1:0] LOOPBACK_ADDR = 32'h0100_007F;

  typedef enum logic [REQ_W-1:0] {
    REQ_SOCKET,
    REQ_POWER,
    REQ_READ,
    REQ_UNUSED
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED,
    ST_ADDED,
    ST_PRESENT,
    ST_FULL,
    ST_REMOVED,
    ST_NOTFOUND,
    ST_DONE
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DEL,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // Query token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [PORT_W-1:0] port;
    logic [EIDX_W-1:0] ridx;
    logic              found;
    logic [PORT_W-1:0] word;
  } tok_t;

endpackage

/* sv/lpt_if.sv */
// Request and response channel interfaces for the listening port table.
`timescale 1ns / 1ps

interface lpt_req_if;
  import lpt_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic              is_tcp;
  logic [ADDR_W-1:0] local_addr;
  logic [PORT_W-1:0] local_port;
  logic              is_listen;
  logic              add_port;
  logic              usb_power;
  logic [EIDX_W-1:0] entry_index;

  modport source (
    output valid, req_type, is_tcp, local_addr, local_port, is_listen, add_port,
           usb_power, entry_index,
    input  ready
  );

  modport sink (
    input  valid, req_type, is_tcp, local_addr, local_port, is_listen, add_port,
           usb_power, entry_index,
    output ready
  );
endinterface

interface lpt_rsp_if;
  import lpt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PCOUNT_W-1:0] port_count;
  logic                filter_active;
  logic [PORT_W-1:0]   table_word;

  modport source (
    output valid, status, port_count, filter_active, table_word,
    input  ready
  );

  modport sink (
    input  valid, status, port_count, filter_active, table_word,
    output ready
  );
endinterface

/* sv/lpt_cell.sv */
// One cell of the port row: holds one port and acts on the passing token.
`timescale 1ns / 1ps

module lpt_cell
  import lpt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [CNT_W-1:0]  count_i,
  input  tok_t              tok_i,
  input  logic [PORT_W-1:0] next_data_i,
  output tok_t              tok_o,
  output logic [PORT_W-1:0] data_o
);

  logic [PORT_W-1:0] data_q, data_d;
  tok_t              tok_q, tok_d;
  logic              live;
  logic              match;

  always_comb begin
    live  = CNT_W'(idx_i) < count_i;
    match = live && (data_q == tok_i.port);
    tok_d  = tok_i;
    data_d = data_q;
    if (tok_i.valid) begin
      case (tok_i.op)
        OP_ADD: begin
          if (match) begin
            tok_d.found = 1'b1;
          end
          // first free cell; every held cell has been compared by now
          if (CNT_W'(idx_i) == count_i && !tok_i.found) begin
            data_d = tok_i.port;
          end
        end
        OP_DEL: begin
          // from the hit onward each cell pulls in its right neighbor
          if (tok_i.found) begin
            data_d = next_data_i;
          end else if (match) begin
            tok_d.found = 1'b1;
            data_d      = next_data_i;
          end
        end
        OP_READ: begin
          if (live && (32'(idx_i) + 32'd1 == 32'(tok_i.ridx)) &&
              (32'(idx_i) < 32'(TABLE_SLOTS))) begin
            tok_d.word = data_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign tok_o  = tok_q;
  assign data_o = data_q;

endmodule

/* sv/lpt_ctrl.sv */
// Request decode, scalar state, token launch and result register.
`timescale 1ns / 1ps

module lpt_ctrl
  import lpt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  lpt_req_if.sink          req_i,
  lpt_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  output tok_t             tok_o,
  input  tok_t             tok_i,
  output logic [CNT_W-1:0] count_o
);

  state_e            state_q, state_d;
  logic              filter_on_q, filter_on_d;
  logic              on_usb_q, on_usb_d;
  logic              enable_q, enable_d;
  logic [CNT_W-1:0]  count_q, count_d;
  tok_t              tok_q, tok_d;
  status_e           res_status_q, res_status_d;
  logic [PORT_W-1:0] res_word_q, res_word_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [PCOUNT_W-1:0] out_count_q, out_count_d;
  logic                out_active_q, out_active_d;
  logic [PORT_W-1:0]   out_word_q, out_word_d;

  logic             accept;
  logic             qualify;
  logic [CNT_W-1:0] new_count;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign qualify     = req_i.is_tcp && (req_i.local_addr != LOOPBACK_ADDR) &&
                       (req_i.local_port != '0) && req_i.is_listen;

  always_comb begin
    state_d      = state_q;
    filter_on_d  = filter_on_q;
    on_usb_d     = on_usb_q;
    enable_d     = enable_q;
    count_d      = count_q;
    tok_d        = '0;
    res_status_d = res_status_q;
    res_word_d   = res_word_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_active_d = out_active_q;
    out_word_d   = out_word_q;
    new_count    = count_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = ST_IGNORED;
          res_word_d   = '0;
          state_d      = S_DONE;
          tok_d.port   = req_i.local_port;
          tok_d.ridx   = req_i.entry_index;
          case (req_e'(req_i.req_type))
            REQ_SOCKET: begin
              if (filter_on_q && qualify) begin
                tok_d.valid = 1'b1;
                tok_d.op    = req_i.add_port ? OP_ADD : OP_DEL;
                state_d     = S_SCAN;
              end
            end
            REQ_POWER: begin
              if (filter_on_q) begin
                on_usb_d     = req_i.usb_power;
                // charging path disables at exactly the slot count
                enable_d     = !req_i.usb_power &&
                               (32'(count_q) < 32'(TABLE_SLOTS));
                res_status_d = ST_DONE;
              end
            end
            REQ_READ: begin
              res_status_d = ST_DONE;
              if (req_i.entry_index == '0) begin
                res_word_d = PORT_W'(enable_q);
              end else begin
                tok_d.valid = 1'b1;
                tok_d.op    = OP_READ;
                state_d     = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (tok_i.valid) begin
          state_d = S_DONE;
          case (tok_i.op)
            OP_READ: begin
              res_status_d = ST_DONE;
              res_word_d   = tok_i.word;
            end
            OP_ADD: begin
              if (tok_i.found) begin
                res_status_d = ST_PRESENT;
              end else if (count_q >= CNT_W'(SET_DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                new_count    = count_q + CNT_W'(1);
                res_status_d = ST_ADDED;
              end
            end
            default: begin
              if (tok_i.found) begin
                new_count    = count_q - CNT_W'(1);
                res_status_d = ST_REMOVED;
              end else begin
                res_status_d = ST_NOTFOUND;
              end
            end
          endcase
          if (tok_i.op != OP_READ) begin
            count_d  = new_count;
            enable_d = !on_usb_q && (32'(new_count) <= 32'(TABLE_SLOTS));
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_count_d  = PCOUNT_W'(count_q);
          out_active_d = enable_q;
          out_word_d   = res_word_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      filter_on_d = cfg_wdata_i;
      enable_d    = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      filter_on_q <= 1'b1;
      on_usb_q    <= 1'b0;
      enable_q    <= 1'b1;
      count_q     <= '0;
      tok_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filter_on_q <= filter_on_d;
      on_usb_q    <= on_usb_d;
      enable_q    <= enable_d;
      count_q     <= count_d;
      tok_q       <= tok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_word_q   <= res_word_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_active_q <= out_active_d;
    out_word_q   <= out_word_d;
  end

  assign tok_o   = tok_q;
  assign count_o = count_q;

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.port_count    = out_count_q;
  assign rsp_o.filter_active = out_active_q;
  assign rsp_o.table_word    = out_word_q;

endmodule

/* sv/listening_port_table_core.sv */
// Top level: listening port table with a row of port cells.
//
// Requests arrive on req_i (valid/ready), one result per request leaves on
// rsp_o (valid/ready). cfg_we_i writes the filter switch from cfg_wdata_i;
// the write also loads the enable word.
// Held ports sit in a row of SET_DEPTH cells, one port each, in order.
// A qualifying socket event or a read of a port word launches a token that
// walks the row one cell per cycle: it searches, appends at the first free
// cell, or on removal makes each cell from the hit onward pull in its right
// neighbor, so order is kept in the same pass. Power events, ignored events
// and reads of the enable word skip the row. One item is worked at a time; a
// new item is taken while the previous result still waits in the output
// register. If the receiver stalls, the finished result of the next item
// waits internally and req_i.ready stays low.
// Reset empties the set, clears USB state and sets filter and enable to 1;
// cell contents are not cleared, only cells below the count are ever read.
`timescale 1ns / 1ps

module listening_port_table_core
  import lpt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  lpt_req_if.sink   req_i,
  lpt_rsp_if.source rsp_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  tok_t              tok  [SET_DEPTH+1];
  logic [PORT_W-1:0] data [SET_DEPTH+1];
  logic [CNT_W-1:0]  count;

  lpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tok_o       (tok[0]),
    .tok_i       (tok[SET_DEPTH]),
    .count_o     (count)
  );

  // past the last cell there is nothing to pull in
  assign data[SET_DEPTH] = '0;

  for (genvar k = 0; k < SET_DEPTH; k++) begin : g_cell
    lpt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (IDX_W'(k)),
      .count_i     (count),
      .tok_i       (tok[k]),
      .next_data_i (data[k+1]),
      .tok_o       (tok[k+1]),
      .data_o      (data[k])
    );
  end

endmodule

/* sim/tb_listening_port_table_core.sv */
// Self-checking testbench for listening_port_table_core: random traffic checked against a shadow table.
`timescale 1ns / 1ps

module tb_listening_port_table_core;
  import lpt_pkg::*;

  typedef struct {
    req_e              kind;
    logic              is_tcp;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic              listen;
    logic              add;
    logic              usb;
    logic [EIDX_W-1:0] idx;
  } port_req_t;

  typedef struct {
    status_e             status;
    logic [PCOUNT_W-1:0] count;
    logic                active;
    logic [PORT_W-1:0]   word;
  } port_reply_t;

  localparam int POOL_SIZE = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  lpt_req_if req_ch ();
  lpt_rsp_if rsp_ch ();

  listening_port_table_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  port_req_t         req_backlog[$];
  port_reply_t       replies_due[$];
  logic [PORT_W-1:0] port_pool[POOL_SIZE];

  // shadow copy of the table, kept in insertion order
  logic [PORT_W-1:0] shadow_ports[$];
  logic              shadow_usb;
  logic              shadow_enable;
  logic              shadow_filter;

  int        err_count    = 0;
  int        items_sent   = 0;
  int        replies_seen = 0;
  int        send_gap     = 0;
  int        stall_left   = 0;
  int        hold_left    = 0;
  int        hold_mark    = 40;
  bit        offering     = 1'b0;
  bit        recv_ready;
  port_req_t on_offer;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic port_reply_t predict_port_table(port_req_t r);
    port_reply_t e;
    int          hit;
    e.status = ST_IGNORED;
    e.word   = '0;
    case (r.kind)
      REQ_SOCKET: begin
        if (shadow_filter && r.is_tcp && r.addr != LOOPBACK_ADDR && r.port != '0 &&
            r.listen) begin
          hit = -1;
          foreach (shadow_ports[i])
            if (hit < 0 && shadow_ports[i] == r.port) hit = i;
          if (r.add) begin
            if (hit >= 0) e.status = ST_PRESENT;
            else if (shadow_ports.size() >= SET_DEPTH) e.status = ST_FULL;
            else begin
              shadow_ports.push_back(r.port);
              e.status = ST_ADDED;
            end
          end else if (hit >= 0) begin
            shadow_ports.delete(hit);
            e.status = ST_REMOVED;
          end else begin
            e.status = ST_NOTFOUND;
          end
          shadow_enable = !shadow_usb && shadow_ports.size() <= TABLE_SLOTS;
        end
      end
      REQ_POWER: begin
        if (shadow_filter) begin
          shadow_usb = r.usb;
          // charging path already turns off at TABLE_SLOTS ports
          shadow_enable = !shadow_usb && shadow_ports.size() < TABLE_SLOTS;
          e.status = ST_DONE;
        end
      end
      REQ_READ: begin
        if (r.idx == '0) e.word = PORT_W'(shadow_enable);
        else if (r.idx <= TABLE_SLOTS && r.idx <= shadow_ports.size())
          e.word = shadow_ports[r.idx - 1];
        e.status = ST_DONE;
      end
      default: ;
    endcase
    e.count  = PCOUNT_W'(shadow_ports.size());
    e.active = shadow_enable;
    return e;
  endfunction

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int pick_gap(int n);
    int r;
    r = $urandom_range(0, 99);
    if ((n / 50) % 4 == 1) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic port_req_t any_req(req_e kind);
    port_req_t r;
    r.kind   = kind;
    r.is_tcp = 1'($urandom);
    r.addr   = ADDR_W'($urandom);
    r.port   = PORT_W'($urandom);
    r.listen = 1'($urandom);
    r.add    = 1'($urandom);
    r.usb    = 1'($urandom);
    r.idx    = EIDX_W'($urandom);
    return r;
  endfunction

  function automatic port_req_t socket_req(logic [PORT_W-1:0] port, logic add);
    port_req_t r;
    r        = any_req(REQ_SOCKET);
    r.is_tcp = 1'b1;
    r.listen = 1'b1;
    r.port   = port;
    r.add    = add;
    if (r.addr == LOOPBACK_ADDR) r.addr = ~r.addr;
    return r;
  endfunction

  task automatic push_raw(port_req_t r);
    req_backlog.push_back(r);
  endtask

  task automatic push_power(logic usb);
    port_req_t r;
    r     = any_req(REQ_POWER);
    r.usb = usb;
    push_raw(r);
  endtask

  task automatic push_read(logic [EIDX_W-1:0] idx);
    port_req_t r;
    r     = any_req(REQ_READ);
    r.idx = idx;
    push_raw(r);
  endtask

  // well-formed socket item with exactly one qualifier broken
  task automatic push_bent_socket(logic [PORT_W-1:0] port, logic add);
    port_req_t r;
    r = socket_req(port, add);
    case ($urandom_range(0, 3))
      0:       r.is_tcp = 1'b0;
      1:       r.addr   = LOOPBACK_ADDR;
      2:       r.port   = '0;
      default: r.listen = 1'b0;
    endcase
    push_raw(r);
  endtask

  task automatic wait_drained();
    while (req_backlog.size() != 0 || offering || replies_due.size() != 0)
      @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_filter(logic v);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    shadow_filter = v;
    shadow_enable = v;
    @(negedge clk_i);
  endtask

  task automatic random_block(int n, int add_pct);
    int                sel;
    logic [PORT_W-1:0] port;
    for (int k = 0; k < n; k++) begin
      sel  = $urandom_range(0, 99);
      port = ($urandom_range(0, 9) == 0) ? PORT_W'($urandom)
                                         : port_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (sel < 60) push_raw(socket_req(port, $urandom_range(0, 99) < add_pct));
      else if (sel < 70) push_bent_socket(port, 1'($urandom));
      else if (sel < 78) push_power(1'($urandom));
      else if (sel < 97) push_read(EIDX_W'($urandom_range(0, 127)));
      else push_raw(any_req(REQ_UNUSED));
    end
  endtask

  task automatic note_mismatch(string msg);
    err_count++;
    if (err_count <= 40) $display("mismatch at %0t, result %0d: %s", $time, replies_seen, msg);
  endtask

  task automatic check_reply();
    port_reply_t e;
    if (replies_due.size() == 0) begin
      note_mismatch("result with no item outstanding");
      return;
    end
    e = replies_due.pop_front();
    if (rsp_ch.status !== e.status)
      note_mismatch($sformatf("status exp %0d got %0d", e.status, rsp_ch.status));
    if (rsp_ch.port_count !== e.count)
      note_mismatch($sformatf("port_count exp %0d got %0d", e.count, rsp_ch.port_count));
    if (rsp_ch.filter_active !== e.active)
      note_mismatch($sformatf("filter_active exp %0b got %0b", e.active, rsp_ch.filter_active));
    if (rsp_ch.table_word !== e.word)
      note_mismatch($sformatf("table_word exp %h got %h", e.word, rsp_ch.table_word));
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        replies_due.push_back(predict_port_table(on_offer));
        offering = 1'b0;
        send_gap = pick_gap(items_sent);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_backlog.size() != 0) begin
          on_offer = req_backlog.pop_front();
          offering = 1'b1;
          items_sent++;
          req_ch.req_type    <= on_offer.kind;
          req_ch.is_tcp      <= on_offer.is_tcp;
          req_ch.local_addr  <= on_offer.addr;
          req_ch.local_port  <= on_offer.port;
          req_ch.is_listen   <= on_offer.listen;
          req_ch.add_port    <= on_offer.add;
          req_ch.usb_power   <= on_offer.usb;
          req_ch.entry_index <= on_offer.idx;
        end
      end
      req_ch.valid <= offering;
    end
  end

  // result monitor; two long holds fill the block so that it stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_reply();
        replies_seen++;
        if (replies_seen == hold_mark) begin
          hold_left = 1500;
          hold_mark = (hold_mark == 40) ? 700 : -1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        recv_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        recv_ready = 1'b0;
      end else begin
        recv_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap(replies_seen);
      end
      rsp_ch.ready <= recv_ready;
    end
  end

  initial begin
    port_req_t r;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = '0;
    req_ch.is_tcp      = 1'b0;
    req_ch.local_addr  = '0;
    req_ch.local_port  = '0;
    req_ch.is_listen   = 1'b0;
    req_ch.add_port    = 1'b0;
    req_ch.usb_power   = 1'b0;
    req_ch.entry_index = '0;
    rsp_ch.ready       = 1'b0;
    shadow_ports.delete();
    shadow_usb    = 1'b0;
    shadow_enable = 1'b1;
    shadow_filter = 1'b1;
    // distinct nonzero ports
    for (int i = 0; i < POOL_SIZE; i++) port_pool[i] = PORT_W'(i * 217) ^ 16'hA5C3;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty reads, field extremes, every rejection path
    push_read('0);
    push_read(EIDX_W'(1));
    push_read('1);
    r = socket_req(16'hFFFF, 1'b1);
    r.addr = '1;
    push_raw(r);
    r = socket_req(16'h0001, 1'b1);
    r.addr = '0;
    push_raw(r);
    push_raw(socket_req(16'hFFFF, 1'b1));
    r = socket_req(16'h0007, 1'b1);
    r.is_tcp = 1'b0;
    push_raw(r);
    r = socket_req(16'h0007, 1'b1);
    r.addr = LOOPBACK_ADDR;
    push_raw(r);
    push_raw(socket_req('0, 1'b1));
    r = socket_req(16'h0007, 1'b1);
    r.listen = 1'b0;
    push_raw(r);
    r = socket_req(16'h0001, 1'b0);
    r.listen = 1'b0;
    push_raw(r);
    push_raw(socket_req(16'h0002, 1'b0));
    push_raw(socket_req(16'hFFFF, 1'b0));
    push_read(EIDX_W'(1));
    push_power(1'b1);
    push_raw(socket_req(16'h0005, 1'b1));
    push_read('0);
    push_power(1'b0);
    push_raw(any_req(REQ_UNUSED));
    push_read(EIDX_W'(2));
    push_read(EIDX_W'(3));

    // filter off: events dropped, reads still served
    write_filter(1'b0);
    push_raw(socket_req(16'h0009, 1'b1));
    push_raw(socket_req(16'h0001, 1'b0));
    push_power(1'b1);
    push_read('0);
    push_read(EIDX_W'(1));
    push_raw(any_req(REQ_UNUSED));
    write_filter(1'b1);

    // clear the directed leftovers, then fill to capacity across the slot boundary
    push_raw(socket_req(16'h0001, 1'b0));
    push_raw(socket_req(16'h0005, 1'b0));
    for (int i = 0; i < SET_DEPTH; i++) begin
      push_raw(socket_req(port_pool[i], 1'b1));
      if (i % 24 == 5) push_read(EIDX_W'($urandom_range(0, 127)));
      if (i == TABLE_SLOTS - 1) begin
        push_power(1'b0);
        push_read('0);
        push_raw(socket_req(port_pool[0], 1'b1));
        push_read('0);
        push_read(EIDX_W'(TABLE_SLOTS));
      end
      if (i == TABLE_SLOTS) begin
        push_read('0);
        push_power(1'b0);
      end
    end
    push_raw(socket_req(port_pool[SET_DEPTH], 1'b1));
    push_raw(socket_req(port_pool[5], 1'b1));
    push_raw(socket_req(port_pool[3], 1'b0));
    push_raw(socket_req(port_pool[SET_DEPTH], 1'b1));
    push_raw(socket_req(port_pool[SET_DEPTH + 1], 1'b1));
    push_raw(socket_req(port_pool[SET_DEPTH - 1], 1'b0));
    push_raw(socket_req(port_pool[0], 1'b0));
    push_read(EIDX_W'(TABLE_SLOTS));
    push_read(EIDX_W'(1));

    random_block(300, 60);
    write_filter(1'b0);
    random_block(50, 50);
    write_filter(1'b1);
    random_block(250, 35);
    random_block(250, 50);

    wait_drained();
    repeat (SET_DEPTH + 16) @(posedge clk_i);
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #25_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
